// ===== rtl/qppt_pkg.sv =====
package qppt_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [17:0] quat_t;
  typedef logic signed [16:0] rvel_t;
  typedef logic        [23:0] gain_t;
  typedef logic signed [17:0] lim_t;

  // body z axis in Q.24
  typedef struct packed {
    logic signed [30:0] x;
    logic signed [30:0] y;
    logic signed [30:0] z;
  } body_t;

  // per-stage load enables of one axis datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } axis_en_t;

  typedef enum logic [2:0] {
    REG_REF_X,
    REG_REF_Y,
    REG_REF_Z,
    REG_KP_XY,
    REG_KD_XY,
    REG_KP_Z,
    REG_KD_Z,
    REG_RV_GAIN
  } reg_idx_t;

  localparam int THRUST_MIN = 65536;
  localparam int THRUST_MAX = 1966080;
  localparam int RV_LIM     = 32768;

  localparam lim_t LIM_POS_XY = 18'sd39322;
  localparam lim_t LIM_VEL_XY = 18'sd65536;
  localparam lim_t LIM_POS_Z  = 18'sd19661;
  localparam lim_t LIM_VEL_Z  = 18'sd49152;
  localparam q16_t GRAVITY_Q  = 32'sd642908;

  localparam q16_t  RST_REF_X   = 32'sd0;
  localparam q16_t  RST_REF_Y   = 32'sd0;
  localparam q16_t  RST_REF_Z   = 32'sd65536;
  localparam gain_t RST_KP_XY   = 24'd655360;
  localparam gain_t RST_KD_XY   = 24'd262144;
  localparam gain_t RST_KP_Z    = 24'd983040;
  localparam gain_t RST_KD_Z    = 24'd393216;
  localparam gain_t RST_RV_GAIN = 24'd32768;

endpackage

// ===== rtl/qppt_if.sv =====
interface qppt_state_if;
  import qppt_pkg::*;

  logic  valid;
  logic  ready;
  q16_t  pos_x;
  q16_t  pos_y;
  q16_t  pos_z;
  q16_t  vel_x;
  q16_t  vel_y;
  q16_t  vel_z;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    output quat_w, quat_x, quat_y, quat_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    input  quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

interface qppt_result_if;
  import qppt_pkg::*;

  logic  valid;
  logic  ready;
  q16_t  acc_x;
  q16_t  acc_y;
  q16_t  acc_z;
  q16_t  thrust;
  rvel_t ref_vel_x;
  rvel_t ref_vel_y;
  rvel_t ref_vel_z;

  modport source (
    output valid, acc_x, acc_y, acc_z, thrust, ref_vel_x, ref_vel_y, ref_vel_z,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, thrust, ref_vel_x, ref_vel_y, ref_vel_z,
    output ready
  );
endinterface

// ===== rtl/qppt_axis.sv =====
module qppt_axis (
  input  logic                clk,
  input  qppt_pkg::axis_en_t  en,
  input  qppt_pkg::q16_t      ref_pos,
  input  qppt_pkg::q16_t      pos,
  input  qppt_pkg::q16_t      vel,
  input  qppt_pkg::gain_t     kp,
  input  qppt_pkg::gain_t     kd,
  input  qppt_pkg::gain_t     rv_gain,
  input  qppt_pkg::lim_t      plim,
  input  qppt_pkg::lim_t      vlim,
  input  qppt_pkg::q16_t      bias,
  output qppt_pkg::q16_t      acc,
  output qppt_pkg::rvel_t     rv
);
  import qppt_pkg::*;

  logic signed [32:0] perr1;
  q16_t               vel1, vel2, vel3;
  logic signed [57:0] prod2;
  lim_t               perrc2, perrc3, perrc4;
  rvel_t              rv3, rv4, rv5, rv6;
  lim_t               verrc4;
  logic signed [42:0] pprod5, dprod5;
  q16_t               acc6;

  lim_t               perrc_next;
  logic signed [41:0] rv_raw;
  rvel_t              rv_next;
  logic signed [32:0] vdiff;
  lim_t               verrc_next;
  logic signed [43:0] pd_sum;
  q16_t               acc_next;

  always_comb begin
    if (perr1 > 33'(plim)) begin
      perrc_next = plim;
    end else if (perr1 < -33'(plim)) begin
      perrc_next = -plim;
    end else begin
      perrc_next = perr1[17:0];
    end

    rv_raw = prod2[57:16];
    if (rv_raw > RV_LIM) begin
      rv_next = 17'(RV_LIM);
    end else if (rv_raw < -RV_LIM) begin
      rv_next = 17'(-RV_LIM);
    end else begin
      rv_next = rv_raw[16:0];
    end

    vdiff = 33'(rv3) - 33'(vel3);
    if (vdiff > 33'(vlim)) begin
      verrc_next = vlim;
    end else if (vdiff < -33'(vlim)) begin
      verrc_next = -vlim;
    end else begin
      verrc_next = vdiff[17:0];
    end

    // |sum >> 16| stays below 2^27, so no saturation is reached
    pd_sum   = 44'(pprod5) + 44'(dprod5);
    acc_next = 32'($signed(pd_sum[43:16])) + bias;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      perr1 <= 33'(ref_pos) - 33'(pos);
      vel1  <= vel;
    end
    if (en.s2) begin
      prod2  <= $signed({1'b0, rv_gain}) * perr1;
      perrc2 <= perrc_next;
      vel2   <= vel1;
    end
    if (en.s3) begin
      rv3    <= rv_next;
      perrc3 <= perrc2;
      vel3   <= vel2;
    end
    if (en.s4) begin
      verrc4 <= verrc_next;
      perrc4 <= perrc3;
      rv4    <= rv3;
    end
    if (en.s5) begin
      pprod5 <= $signed({1'b0, kp}) * perrc4;
      dprod5 <= $signed({1'b0, kd}) * verrc4;
      rv5    <= rv4;
    end
    if (en.s6) begin
      acc6 <= acc_next;
      rv6  <= rv5;
    end
  end

  assign acc = acc6;
  assign rv  = rv6;

endmodule

// ===== rtl/quad_position_pd_thrust.sv =====
// throughput: one estimate per cycle while the output is not stalled, set by
// the 8-stage pipeline with per-stage valid bits
// a stalled output holds its stage; bubbles in earlier stages still fill
// reset (synchronous, active high) clears all valid bits and loads the
// register defaults; datapath registers are not reset
module quad_position_pd_thrust (
  input  logic                  clk,
  input  logic                  rst,
  qppt_state_if.sink            state,
  qppt_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [31:0]           cfg_data
);
  import qppt_pkg::*;

  q16_t  ref_x, ref_y, ref_z;
  gain_t kp_xy, kd_xy, kp_z, kd_z, rv_gain;

  logic [8:1] v, en;
  axis_en_t   axis_en;

  logic signed [35:0] qxz1, qwy1, qyz1, qwx1, qxx1, qyy1;
  body_t              body [2:6];
  body_t              body_next;
  logic signed [38:0] tx, ty, tz;

  q16_t  acc_x6, acc_y6, acc_z6;
  rvel_t rv_x6, rv_y6, rv_z6;

  logic signed [62:0] px7, py7, pz7;
  q16_t  acc_x7, acc_y7, acc_z7;
  rvel_t rv_x7, rv_y7, rv_z7;

  q16_t  acc_x8, acc_y8, acc_z8, thrust8;
  rvel_t rv_x8, rv_y8, rv_z8;

  logic signed [64:0] tsum;
  logic signed [40:0] th_raw, th_lo;
  q16_t               thrust_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x   <= RST_REF_X;
      ref_y   <= RST_REF_Y;
      ref_z   <= RST_REF_Z;
      kp_xy   <= RST_KP_XY;
      kd_xy   <= RST_KD_XY;
      kp_z    <= RST_KP_Z;
      kd_z    <= RST_KD_Z;
      rv_gain <= RST_RV_GAIN;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_REF_X:   ref_x   <= cfg_data;
        REG_REF_Y:   ref_y   <= cfg_data;
        REG_REF_Z:   ref_z   <= cfg_data;
        REG_KP_XY:   kp_xy   <= cfg_data[23:0];
        REG_KD_XY:   kd_xy   <= cfg_data[23:0];
        REG_KP_Z:    kp_z    <= cfg_data[23:0];
        REG_KD_Z:    kd_z    <= cfg_data[23:0];
        REG_RV_GAIN: rv_gain <= cfg_data[23:0];
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[8] = !v[8] || result.ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en & {v[7:1], state.valid}) | (~en & v);
    end
  end

  assign state.ready  = en[1];
  assign result.valid = v[8];

  assign axis_en.s1 = en[1];
  assign axis_en.s2 = en[2];
  assign axis_en.s3 = en[3];
  assign axis_en.s4 = en[4];
  assign axis_en.s5 = en[5];
  assign axis_en.s6 = en[6];

  qppt_axis u_axis_x (
    .clk     (clk),
    .en      (axis_en),
    .ref_pos (ref_x),
    .pos     (state.pos_x),
    .vel     (state.vel_x),
    .kp      (kp_xy),
    .kd      (kd_xy),
    .rv_gain (rv_gain),
    .plim    (LIM_POS_XY),
    .vlim    (LIM_VEL_XY),
    .bias    ('0),
    .acc     (acc_x6),
    .rv      (rv_x6)
  );

  qppt_axis u_axis_y (
    .clk     (clk),
    .en      (axis_en),
    .ref_pos (ref_y),
    .pos     (state.pos_y),
    .vel     (state.vel_y),
    .kp      (kp_xy),
    .kd      (kd_xy),
    .rv_gain (rv_gain),
    .plim    (LIM_POS_XY),
    .vlim    (LIM_VEL_XY),
    .bias    ('0),
    .acc     (acc_y6),
    .rv      (rv_y6)
  );

  qppt_axis u_axis_z (
    .clk     (clk),
    .en      (axis_en),
    .ref_pos (ref_z),
    .pos     (state.pos_z),
    .vel     (state.vel_z),
    .kp      (kp_z),
    .kd      (kd_z),
    .rv_gain (rv_gain),
    .plim    (LIM_POS_Z),
    .vlim    (LIM_VEL_Z),
    .bias    (GRAVITY_Q),
    .acc     (acc_z6),
    .rv      (rv_z6)
  );

  // body z axis: 2(xz+wy), 2(yz-wx), 1-2(x^2+y^2), floored to Q.24
  always_comb begin
    tx = 39'(qxz1) + 39'(qwy1);
    ty = 39'(qyz1) - 39'(qwx1);
    tz = 39'sd2147483648 - 39'(qxx1) - 39'(qyy1);
    body_next.x = 31'(tx >>> 7);
    body_next.y = 31'(ty >>> 7);
    body_next.z = 31'(tz >>> 7);
  end

  // thrust: projection, floor, clamp to minimum then maximum
  always_comb begin
    tsum   = 65'(px7) + 65'(py7) + 65'(pz7);
    th_raw = tsum[64:24];
    th_lo  = (th_raw < THRUST_MIN) ? 41'(THRUST_MIN) : th_raw;
    thrust_next = (th_lo > THRUST_MAX) ? 32'(THRUST_MAX) : th_lo[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qxz1 <= state.quat_x * state.quat_z;
      qwy1 <= state.quat_w * state.quat_y;
      qyz1 <= state.quat_y * state.quat_z;
      qwx1 <= state.quat_w * state.quat_x;
      qxx1 <= state.quat_x * state.quat_x;
      qyy1 <= state.quat_y * state.quat_y;
    end
    if (en[2]) begin
      body[2] <= body_next;
    end
    for (int k = 3; k <= 6; k++) begin
      if (en[k]) begin
        body[k] <= body[k-1];
      end
    end
    if (en[7]) begin
      px7    <= acc_x6 * body[6].x;
      py7    <= acc_y6 * body[6].y;
      pz7    <= acc_z6 * body[6].z;
      acc_x7 <= acc_x6;
      acc_y7 <= acc_y6;
      acc_z7 <= acc_z6;
      rv_x7  <= rv_x6;
      rv_y7  <= rv_y6;
      rv_z7  <= rv_z6;
    end
    if (en[8]) begin
      thrust8 <= thrust_next;
      acc_x8  <= acc_x7;
      acc_y8  <= acc_y7;
      acc_z8  <= acc_z7;
      rv_x8   <= rv_x7;
      rv_y8   <= rv_y7;
      rv_z8   <= rv_z7;
    end
  end

  assign result.acc_x     = acc_x8;
  assign result.acc_y     = acc_y8;
  assign result.acc_z     = acc_z8;
  assign result.thrust    = thrust8;
  assign result.ref_vel_x = rv_x8;
  assign result.ref_vel_y = rv_y8;
  assign result.ref_vel_z = rv_z8;

  a_thrust_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.thrust >= THRUST_MIN && result.thrust <= THRUST_MAX))
    else $error("thrust outside limits");

  a_rv_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.ref_vel_x >= -RV_LIM && result.ref_vel_x <= RV_LIM &&
                      result.ref_vel_y >= -RV_LIM && result.ref_vel_y <= RV_LIM &&
                      result.ref_vel_z >= -RV_LIM && result.ref_vel_z <= RV_LIM))
    else $error("reference velocity outside limits");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v && !result.ready) |-> !state.ready)
    else $error("transfer taken into a full stalled pipeline");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (state.valid && state.ready) |=> v[1])
    else $error("accepted item lost at first stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v[8] && !result.ready) |=> v[8])
    else $error("stalled result dropped");

endmodule
